// File: rtl/slcd_pkg.sv
`default_nettype none

package slcd_pkg;

    // received characters that frame and command use
    localparam logic [7:0] CH_END   = 8'h3C;
    localparam logic [7:0] CH_START = 8'h3E;
    localparam logic [7:0] CH_M     = 8'h4D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_SEVEN = 8'h37;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_O     = 8'h4F;
    localparam logic [7:0] CH_N     = 8'h4E;
    localparam logic [7:0] CH_F     = 8'h46;

    // lamps that exist, digit must stay below this
    localparam int LAMP_COUNT = 8;

    localparam int BUF_DEPTH = 7;
    localparam logic [3:0] LEN_MAX = 4'd15;

    // reply texts, good reply padded to the longer length
    localparam int REPLY_DEPTH    = 5;
    localparam int REPLY_GOOD_LEN = 4;
    localparam int REPLY_BAD_LEN  = 5;
    localparam logic [7:0] REPLY_GOOD [REPLY_DEPTH] = '{8'h3E, 8'h4F, 8'h4B, 8'h3C, 8'h00};
    localparam logic [7:0] REPLY_BAD  [REPLY_DEPTH] = '{8'h3E, 8'h45, 8'h52, 8'h52, 8'h3C};

    typedef struct packed {
        logic [7:0] rx_byte;
    } slcd_in_t;

    typedef struct packed {
        logic [7:0] tx_char;
        logic       last_char;
        logic       reply_ok;
        logic [7:0] lamp_bits;
    } slcd_out_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] ch;
        logic       last;
    } slcd_cell_t;

    typedef struct packed {
        logic       ok;
        logic       turn_on;
        logic [2:0] lamp;
    } slcd_check_t;

endpackage

`default_nettype wire

// File: rtl/slcd_if.sv
`default_nettype none

interface slcd_if #(parameter type T = logic [7:0]) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/slcd_reply_cell.sv
`default_nettype none

module slcd_reply_cell
    import slcd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       load,
    input  slcd_cell_t load_val,
    input  logic       shift,
    input  slcd_cell_t from_next,
    output slcd_cell_t slot
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] ch_reg;
    logic [7:0] ch_next;
    logic       last_reg;
    logic       last_next;

    always_comb
    begin
        valid_next = valid_reg;
        ch_next    = ch_reg;
        last_next  = last_reg;
        if (load)
        begin
            valid_next = load_val.valid;
            ch_next    = load_val.ch;
            last_next  = load_val.last;
        end
        else if (shift)
        begin
            valid_next = from_next.valid;
            ch_next    = from_next.ch;
            last_next  = from_next.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ch_reg   <= ch_next;
        last_reg <= last_next;
    end

    assign slot = '{valid: valid_reg, ch: ch_reg, last: last_reg};

endmodule

`default_nettype wire

// File: rtl/slcd_frame_store.sv
`default_nettype none

module slcd_frame_store
    import slcd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        wr_en,
    input  logic [7:0]  wr_byte,
    output slcd_check_t check
);

    logic [3:0] len_reg;
    logic [3:0] len_next;
    logic [7:0] buf_reg [BUF_DEPTH];

    logic       len_seven;
    logic       len_eight;
    logic       head_ok;
    logic       digit_ok;
    logic [2:0] lamp_idx;
    logic       on_ok;
    logic       off_ok;

    always_comb
    begin
        len_next = len_reg;
        if (wr_en)
        begin
            if (wr_byte == CH_END)
            begin
                len_next = '0;
            end
            else if (len_reg != LEN_MAX)
            begin
                len_next = len_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
        end
        else
        begin
            len_reg <= len_next;
        end
    end

    // each entry takes the byte that arrives at its own position
    for (genvar i = 0; i < BUF_DEPTH; i++)
    begin : g_buf
        always_ff @(posedge clk)
        begin
            if (wr_en && (len_reg == 4'(i)))
            begin
                buf_reg[i] <= wr_byte;
            end
        end
    end

    // length counted before the end byte: six for on, seven for off
    assign len_seven = (len_reg == 4'd6);
    assign len_eight = (len_reg == 4'd7);
    assign lamp_idx  = buf_reg[2][2:0];
    assign digit_ok  = (buf_reg[2] >= CH_ZERO) && (buf_reg[2] <= CH_SEVEN)
                       && (int'(lamp_idx) < LAMP_COUNT);
    assign head_ok   = (buf_reg[0] == CH_START) && (buf_reg[1] == CH_M)
                       && (buf_reg[3] == CH_SEMI) && (buf_reg[4] == CH_O);
    assign on_ok     = len_seven && (buf_reg[5] == CH_N);
    assign off_ok    = len_eight && (buf_reg[5] == CH_F) && (buf_reg[6] == CH_F);

    assign check = '{ok: head_ok && digit_ok && (on_ok || off_ok),
                     turn_on: len_seven,
                     lamp: lamp_idx};

endmodule

`default_nettype wire

// File: rtl/serial_lamp_command_decoder.sv
`default_nettype none

// serial lamp command decoder
//
// rx carries received characters, one request per byte. a frame ends on '<'
// and is checked as ">Mn;ON<" or ">Mn;OFF<". a good frame switches lamp n
// and answers ">OK<", anything else answers ">ERR<" and leaves the lamps.
// tx carries one reply character per request, with last_char on the final
// one, reply_ok and the lamp register as it stands after the frame.
//
// ordinary bytes are taken at one per cycle at all times. a '<' is taken
// once the reply row holds at most the final character of the previous
// reply and that one is leaving; its first reply character shows on tx the
// next cycle. a reply of 4 (ok) or 5 (err) characters goes at full tx rate,
// one character per cycle out of a row of five shifting cells.
//
// reset clears the frame length, the lamps and the reply row. a stall on
// tx freezes the row; ordinary bytes keep flowing, a '<' waits.

module serial_lamp_command_decoder
    import slcd_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    slcd_if.sink   rx,
    slcd_if.source tx
);

    slcd_check_t check;
    slcd_cell_t  chain [REPLY_DEPTH + 1];
    slcd_cell_t  load_val [REPLY_DEPTH];

    logic       is_end;
    logic       rx_fire;
    logic       shift;
    logic       can_load;
    logic       load;
    logic [7:0] lamp_mask;
    logic [7:0] lamp_reg;
    logic [7:0] lamp_next;
    logic       reply_ok_reg;
    logic       reply_ok_next;

    assign is_end  = (rx.data.rx_byte == CH_END);

    // head is the output register, the row moves when it is free or taken
    assign shift    = tx.ready || !chain[0].valid;
    // nothing behind the head, so a new reply fits in as it leaves
    assign can_load = shift && !chain[1].valid;

    assign rx.ready = !is_end || can_load;
    assign rx_fire  = rx.valid && rx.ready;
    assign load     = rx_fire && is_end;

    slcd_frame_store u_frame (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (rx_fire),
        .wr_byte (rx.data.rx_byte),
        .check   (check)
    );

    // lamp update at the frame end
    assign lamp_mask = 8'd1 << check.lamp;

    always_comb
    begin
        lamp_next     = lamp_reg;
        reply_ok_next = reply_ok_reg;
        if (load)
        begin
            reply_ok_next = check.ok;
            if (check.ok)
            begin
                lamp_next = check.turn_on ? (lamp_reg | lamp_mask) : (lamp_reg & ~lamp_mask);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lamp_reg     <= '0;
            reply_ok_reg <= 1'b0;
        end
        else
        begin
            lamp_reg     <= lamp_next;
            reply_ok_reg <= reply_ok_next;
        end
    end

    // empty cell feeds the tail of the row
    assign chain[REPLY_DEPTH] = '0;

    for (genvar i = 0; i < REPLY_DEPTH; i++)
    begin : g_cell
        assign load_val[i] = check.ok
            ? slcd_cell_t'{valid: (i < REPLY_GOOD_LEN), ch: REPLY_GOOD[i],
                           last: (i == REPLY_GOOD_LEN - 1)}
            : slcd_cell_t'{valid: (i < REPLY_BAD_LEN), ch: REPLY_BAD[i],
                           last: (i == REPLY_BAD_LEN - 1)};

        slcd_reply_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .load      (load),
            .load_val  (load_val[i]),
            .shift     (shift),
            .from_next (chain[i + 1]),
            .slot      (chain[i])
        );
    end

    assign tx.valid = chain[0].valid;
    assign tx.data  = '{tx_char: chain[0].ch, last_char: chain[0].last,
                        reply_ok: reply_ok_reg, lamp_bits: lamp_reg};

endmodule

`default_nettype wire

// File: rtl/slcd_checker.sv
`default_nettype none

module slcd_checker
    import slcd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      rx_valid,
    input  logic      rx_ready,
    input  slcd_in_t  rx_data,
    input  logic      tx_valid,
    input  logic      tx_ready,
    input  slcd_out_t tx_data
);

    // stalled reply character holds
    a_tx_hold: assert property (@(posedge clk) disable iff (!rst_n)
        tx_valid && !tx_ready |=> tx_valid && $stable(tx_data))
        else $error("reply character changed under stall");

    // a reply runs without gaps and keeps its status and lamps
    a_reply_cont: assert property (@(posedge clk) disable iff (!rst_n)
        tx_valid && tx_ready && !tx_data.last_char |=>
            tx_valid && (tx_data.reply_ok == $past(tx_data.reply_ok))
            && (tx_data.lamp_bits == $past(tx_data.lamp_bits)))
        else $error("reply broken or status changed inside reply");

    // the character after a reply end opens a new reply
    a_reply_start: assert property (@(posedge clk) disable iff (!rst_n)
        tx_valid && tx_ready && tx_data.last_char |=>
            !tx_valid || (tx_data.tx_char == CH_START))
        else $error("reply does not open with start character");

    // ordinary bytes are never held off
    a_rx_plain: assert property (@(posedge clk) disable iff (!rst_n)
        rx_valid && (rx_data.rx_byte != CH_END) |-> rx_ready)
        else $error("ordinary byte stalled");

endmodule

bind serial_lamp_command_decoder slcd_checker u_slcd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .rx_valid (rx.valid),
    .rx_ready (rx.ready),
    .rx_data  (rx.data),
    .tx_valid (tx.valid),
    .tx_ready (tx.ready),
    .tx_data  (tx.data)
);

`default_nettype wire

// File: bench/tb_top.sv
`default_nettype none

// bench for the serial lamp command decoder
//
// rx requests carry received bytes, tx requests carry reply characters.
// every rx request the block takes is also fed to a frame tracker kept here,
// which predicts the reply characters that a closing '<' must produce. the
// tx side pops them oldest first and checks each field.

module tb_top;
    import slcd_pkg::*;

    // cycles the whole run may take before it is declared hung
    localparam int TIMEOUT_CYCLES = 400_000;
    localparam int RANDOM_BYTES   = 450;
    // cycles left to run once the last reply character has come
    localparam int SETTLE_CYCLES  = 20;

    typedef struct {
        string      text;
        bit         typed;   // reply given by hand below
        bit         ok;
        logic [7:0] lamps;
    } directed_row_t;

    // hand-given reply for one frame, keyed by how many frames closed so far
    typedef struct {
        int unsigned frame_no;
        bit          ok;
        logic [7:0]  lamps;
    } typed_reply_t;

    logic clk;
    logic rst_n;

    slcd_if #(.T(slcd_in_t))  rx_if ();
    slcd_if #(.T(slcd_out_t)) tx_if ();

    serial_lamp_command_decoder u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_if),
        .tx    (tx_if)
    );

    // frame tracker state, mirrors what the block holds
    logic [7:0] frame_bytes [BUF_DEPTH] = '{default: 8'h00};
    logic [3:0] frame_len  = 4'd0;
    logic [7:0] lamp_state = 8'h00;

    slcd_out_t    reply_chars_due [$];
    typed_reply_t typed_replies [$];

    int unsigned frames_closed = 0;
    int unsigned frames_good   = 0;
    int unsigned frames_bad    = 0;
    int unsigned chars_checked = 0;
    int unsigned bytes_sent    = 0;
    int unsigned ends_sent     = 0;
    int unsigned sender_calm   = 0;
    int unsigned failures      = 0;

    // directed frames; a zero byte goes out just before the first row
    directed_row_t directed_rows [7] = '{
        // zero byte plus '<' right after reset: too short, lamps still off
        '{"<",                        1'b1, 1'b0, 8'h00},
        // top lamp on
        '{">M7;ON<",                  1'b1, 1'b1, 8'h80},
        // bottom lamp on, left to the tracker
        '{">M0;ON<",                  1'b0, 1'b0, 8'h00},
        // top lamp off again
        '{">M7;OFF<",                 1'b1, 1'b1, 8'h01},
        // digit past the last lamp
        '{">M8;ON<",                  1'b1, 1'b0, 8'h01},
        // seven bytes but no N
        '{">M1;OF<",                  1'b1, 1'b0, 8'h01},
        // long frame: all-ones bytes, stray '>', length count pinned at max
        '{">M1;ON\377>>>>>>>>\377<",  1'b1, 1'b0, 8'h01}
    };

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // queue the reply characters of one closed frame
    function automatic void push_reply(input bit ok, input logic [7:0] lamps);
        slcd_out_t c;
        int        n;
        n = ok ? REPLY_GOOD_LEN : REPLY_BAD_LEN;
        for (int k = 0; k < n; k++)
        begin
            c.tx_char   = ok ? REPLY_GOOD[k] : REPLY_BAD[k];
            c.last_char = (k == n - 1);
            c.reply_ok  = ok;
            c.lamp_bits = lamps;
            reply_chars_due.push_back(c);
        end
    endfunction

    // frame tracker: take one received byte, predict the reply on '<'
    function automatic void track_rx_byte(input logic [7:0] b);
        bit         ok;
        logic [7:0] digit;
        logic [2:0] lamp;
        if (frame_len < BUF_DEPTH)
            frame_bytes[frame_len] = b;
        if (frame_len != LEN_MAX)
            frame_len = frame_len + 4'd1;
        if (b != CH_END)
            return;

        digit = frame_bytes[2];
        lamp  = 3'(digit - CH_ZERO);
        ok = (frame_len == 4'd7 || frame_len == 4'd8)
            && frame_bytes[0] == CH_START && frame_bytes[1] == CH_M
            && digit >= CH_ZERO && digit <= CH_SEVEN
            && int'(digit - CH_ZERO) < LAMP_COUNT
            && frame_bytes[3] == CH_SEMI && frame_bytes[4] == CH_O
            && ((frame_len == 4'd7) ? frame_bytes[5] == CH_N
                                    : (frame_bytes[5] == CH_F && frame_bytes[6] == CH_F));
        frame_len = 4'd0;
        frames_closed++;

        if (ok)
        begin
            // seven bytes turn the lamp on, eight (OFF) turn it off
            if (frame_bytes[5] == CH_N)
                lamp_state[lamp] = 1'b1;
            else
                lamp_state[lamp] = 1'b0;
            frames_good++;
        end
        else
            frames_bad++;

        // a hand-given reply replaces the tracked one for its frame
        if (typed_replies.size() != 0 && typed_replies[0].frame_no == frames_closed)
        begin
            push_reply(typed_replies[0].ok, typed_replies[0].lamps);
            void'(typed_replies.pop_front());
        end
        else
            push_reply(ok, lamp_state);
    endfunction

    // watch both channels; predictions first, then the reply check
    always @(posedge clk)
    begin
        slcd_out_t want;
        if (rst_n && rx_if.valid && rx_if.ready)
            track_rx_byte(rx_if.data.rx_byte);
        if (rst_n && tx_if.valid && tx_if.ready)
        begin
            if (reply_chars_due.size() == 0)
            begin
                $error("reply character %h with no frame pending", tx_if.data.tx_char);
                failures++;
            end
            else
            begin
                want = reply_chars_due.pop_front();
                chars_checked++;
                if (tx_if.data.tx_char !== want.tx_char)
                begin
                    $error("tx_char: expected %h, got %h", want.tx_char, tx_if.data.tx_char);
                    failures++;
                end
                if (tx_if.data.last_char !== want.last_char)
                begin
                    $error("last_char: expected %b, got %b",
                           want.last_char, tx_if.data.last_char);
                    failures++;
                end
                if (tx_if.data.reply_ok !== want.reply_ok)
                begin
                    $error("reply_ok: expected %b, got %b", want.reply_ok, tx_if.data.reply_ok);
                    failures++;
                end
                if (tx_if.data.lamp_bits !== want.lamp_bits)
                begin
                    $error("lamp_bits: expected %h, got %h",
                           want.lamp_bits, tx_if.data.lamp_bits);
                    failures++;
                end
            end
        end
    end

    // idle cycles after an rx request: mostly none or short, a few long,
    // now and then a calm stretch with no idling at all
    function automatic int unsigned sender_gap();
        int unsigned r;
        if (sender_calm != 0)
        begin
            sender_calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            sender_calm = $urandom_range(20, 60);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // one rx request, held until taken, then an optional idle gap
    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        rx_if.valid        <= 1'b1;
        rx_if.data.rx_byte <= b;
        @(posedge clk);
        while (!rx_if.ready)
            @(posedge clk);
        bytes_sent++;
        if (b == CH_END)
            ends_sent++;
        gap = sender_gap();
        if (gap != 0)
        begin
            rx_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // hold rx idle until every predicted reply character has come back
    task automatic drain_replies();
        rx_if.valid <= 1'b0;
        // let the request just taken reach the tracker first
        @(posedge clk);
        while (reply_chars_due.size() != 0)
            @(posedge clk);
    endtask

    // one random frame: mostly well formed with random lamp and keyword,
    // some damaged by one changed, added or dropped byte, the rest noise
    task automatic send_random_frame();
        logic [7:0]  frame_text [$];
        logic [7:0]  digit;
        int unsigned r;
        int unsigned pos;
        int unsigned len;
        r = $urandom_range(0, 99);
        if (r < 80)
        begin
            if ($urandom_range(0, 9) != 0)
                digit = 8'(CH_ZERO + $urandom_range(0, 7));
            else
                digit = 8'($urandom_range(8'h2E, 8'h3A));
            frame_text = '{CH_START, CH_M, digit, CH_SEMI, CH_O};
            if ($urandom_range(0, 1) != 0)
                frame_text.push_back(CH_N);
            else
            begin
                frame_text.push_back(CH_F);
                frame_text.push_back(CH_F);
            end
            frame_text.push_back(CH_END);
            if (r >= 60)
            begin
                pos = $urandom_range(0, frame_text.size() - 2);
                case ($urandom_range(0, 2))
                    0: frame_text[pos] = 8'($urandom_range(0, 255));
                    1: frame_text.insert(pos, ($urandom_range(0, 1) != 0)
                                              ? CH_START : 8'($urandom_range(0, 255)));
                    default: frame_text.delete(pos);
                endcase
            end
        end
        else
        begin
            // noise, at times long enough to pin the length count at its max
            len = $urandom_range(0, 25);
            repeat (len)
                frame_text.push_back(($urandom_range(0, 3) == 0)
                                     ? CH_START : 8'($urandom_range(0, 255)));
            frame_text.push_back(CH_END);
        end
        foreach (frame_text[k])
            send_byte(frame_text[k]);
    endtask

    // tx pacing: stalls of random length, mostly short, a few long,
    // with some long stretches of steady ready
    initial
    begin : tx_pacing
        int unsigned r;
        int unsigned low;
        int unsigned high;
        tx_if.ready = 1'b0;
        @(posedge clk);
        forever
        begin
            r    = $urandom_range(0, 99);
            low  = (r < 45) ? 0 : (r < 90) ? $urandom_range(1, 3) : $urandom_range(8, 30);
            high = ($urandom_range(0, 99) < 8) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 10);
            if (low != 0)
            begin
                tx_if.ready <= 1'b0;
                repeat (low) @(posedge clk);
            end
            tx_if.ready <= 1'b1;
            repeat (high) @(posedge clk);
        end
    end

    // stimulus and end of run
    initial
    begin : stimulus
        int unsigned directed_bytes;
        rst_n       = 1'b0;
        rx_if.valid = 1'b0;
        rx_if.data  = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed part: lowest byte first, then the table
        send_byte(8'h00);
        for (int i = 0; i < $size(directed_rows); i++)
        begin
            if (directed_rows[i].typed)
                typed_replies.push_back('{ends_sent + 1, directed_rows[i].ok,
                                          directed_rows[i].lamps});
            for (int j = 0; j < directed_rows[i].text.len(); j++)
                send_byte(directed_rows[i].text[j]);
        end
        // sender waits for the block to go quiet before the random part
        drain_replies();
        directed_bytes = bytes_sent;

        // random part, with an occasional full drain in between
        while (bytes_sent < directed_bytes + RANDOM_BYTES)
        begin
            send_random_frame();
            if ($urandom_range(0, 29) == 0)
                drain_replies();
        end

        drain_replies();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("sent %0d bytes in %0d frames: %0d switched a lamp, %0d were refused",
                 bytes_sent, frames_closed, frames_good, frames_bad);
        $display("checked %0d reply characters, final lamps %h",
                 chars_checked, lamp_state);
        if (failures == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // watchdog
    initial
    begin
        repeat (TIMEOUT_CYCLES) @(posedge clk);
        $error("run hung with %0d reply characters still due", reply_chars_due.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire

// File: serial_lamp_command_decoder.f
rtl/slcd_pkg.sv
rtl/slcd_if.sv
rtl/slcd_reply_cell.sv
rtl/slcd_frame_store.sv
rtl/serial_lamp_command_decoder.sv
rtl/slcd_checker.sv
bench/tb_top.sv
